// ===== design/alarm_persistence_filter_unit_macros.svh =====
// Shared assertion macros for the alarm persistence filter.
`ifndef ALARM_PERSISTENCE_FILTER_UNIT_MACROS_SVH
`define ALARM_PERSISTENCE_FILTER_UNIT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define APF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("apf assertion failed");

// Condition must never be true outside reset.
`define APF_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("apf forbidden condition seen");

`endif

// ===== design/apf_pkg.sv =====
`timescale 1ns / 1ps

package apf_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int DESC_BITS    = 8;

  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam int          COUNT_W   = 4;
  localparam int          KIND_W    = 2;
  localparam int          ACT_W     = 2;
  localparam int          CHAN_W    = 4;
  localparam int          DESC_IN_W = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
  localparam logic [COUNT_W-1:0] THRESH_RESET  = COUNT_W'(5);

  localparam logic [KIND_W-1:0] KIND_REPORT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ROUND  = 2'd2;

  localparam logic [ACT_W-1:0] ACT_NONE   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ADD    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;
  localparam logic [ACT_W-1:0] ACT_READD  = 2'd3;

  // Per-channel status seen by the query logic.
  typedef struct packed {
    logic needed;
    logic flag;
    logic desc_changed;
  } chan_stat_t;

endpackage

// ===== design/alarm_persistence_filter_unit.sv =====
`timescale 1ns / 1ps

// Alarm persistence filter: takes one word per cycle (fault report, query or
// end of polling round). Each word is registered on acceptance and fully
// handled in the next cycle by short logic over the per-channel counter cells,
// unless it is a query and a result still waits at a stalled output; a query's
// result word is loaded into the output register when the query is handled and
// is held until taken. A round end updates all channels in parallel when it is
// handled. Throughput is one word per cycle, limited only by the single result
// register when the output is stalled.
module alarm_persistence_filter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [apf_pkg::COUNT_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [apf_pkg::KIND_W-1:0]    kind_i,
  input  logic [apf_pkg::CHAN_W-1:0]    channel_i,
  input  logic [apf_pkg::DESC_IN_W-1:0] desc_code_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [apf_pkg::ACT_W-1:0]     action_o,
  output logic                          alarm_needed_o
);

  logic [apf_pkg::COUNT_W-1:0]   thresh_q;
  logic                          in_vld_q;
  logic [apf_pkg::KIND_W-1:0]    kind_q;
  logic [apf_pkg::CHAN_W-1:0]    ch_q;
  logic [apf_pkg::DESC_IN_W-1:0] desc_q;
  logic                          out_vld_q;
  logic [apf_pkg::ACT_W-1:0]     act_q, act_d;
  logic                          need_q, need_d;

  logic                          is_query;
  logic                          proceed;
  logic                          accept;
  logic                          ch_valid;
  logic [apf_pkg::CH_IDX_W-1:0]  ch_idx;
  logic [apf_pkg::DESC_BITS-1:0] desc_keep;
  apf_pkg::chan_stat_t           stat [apf_pkg::NUM_CHANNELS];
  apf_pkg::chan_stat_t           sel;

  assign is_query   = (kind_q == apf_pkg::KIND_QUERY);
  assign proceed    = in_vld_q && (!is_query || !out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !proceed;
  assign accept     = in_valid_i && !in_stall_o;
  assign ch_valid   = (32'(ch_q) < apf_pkg::NUM_CHANNELS);
  assign ch_idx     = apf_pkg::CH_IDX_W'(ch_q);
  assign desc_keep  = apf_pkg::DESC_BITS'(desc_q);

  for (genvar i = 0; i < apf_pkg::NUM_CHANNELS; i++) begin : g_chan
    apf_chan u_chan (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .thresh_i    (thresh_q),
      .report_en_i (proceed && (kind_q == apf_pkg::KIND_REPORT) && ch_valid &&
                    (ch_idx == apf_pkg::CH_IDX_W'(i))),
      .close_en_i  (proceed && (kind_q == apf_pkg::KIND_ROUND)),
      .desc_i      (desc_keep),
      .stat_o      (stat[i])
    );
  end

  assign sel = stat[ch_idx];

  always_comb begin
    act_d  = apf_pkg::ACT_NONE;
    need_d = 1'b0;
    if (ch_valid) begin
      need_d = sel.needed;
      case ({sel.flag, sel.needed})
        2'b01:   act_d = apf_pkg::ACT_ADD;
        2'b10:   act_d = apf_pkg::ACT_REMOVE;
        2'b11:   act_d = sel.desc_changed ? apf_pkg::ACT_READD : apf_pkg::ACT_NONE;
        default: act_d = apf_pkg::ACT_NONE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q  <= apf_pkg::THRESH_RESET;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thresh_q <= cfg_wdata_i;
      end
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (proceed) begin
        in_vld_q <= 1'b0;
      end
      if (proceed && is_query) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      ch_q   <= channel_i;
      desc_q <= desc_code_i;
    end
    if (proceed && is_query) begin
      act_q  <= act_d;
      need_q <= need_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign action_o       = act_q;
  assign alarm_needed_o = need_q;

endmodule

// ===== design/apf_chan.sv =====
`timescale 1ns / 1ps

module apf_chan (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [apf_pkg::COUNT_W-1:0]   thresh_i,
  input  logic                          report_en_i,
  input  logic                          close_en_i,
  input  logic [apf_pkg::DESC_BITS-1:0] desc_i,
  output apf_pkg::chan_stat_t           stat_o
);

  logic [apf_pkg::COUNT_W-1:0]   cur_q, cur_d;
  logic [apf_pkg::COUNT_W-1:0]   last_q, last_d;
  logic                          flag_q, flag_d;
  logic [apf_pkg::DESC_BITS-1:0] cdesc_q, cdesc_d;
  logic [apf_pkg::DESC_BITS-1:0] pdesc_q, pdesc_d;
  logic [apf_pkg::COUNT_W:0]     inc;
  logic                          needed;

  assign needed = (cur_q > last_q) && (cur_q >= thresh_i);
  assign inc    = {1'b0, last_q} + {{apf_pkg::COUNT_W{1'b0}}, 1'b1};

  always_comb begin
    cur_d   = cur_q;
    last_d  = last_q;
    flag_d  = flag_q;
    cdesc_d = cdesc_q;
    pdesc_d = pdesc_q;
    if (report_en_i) begin
      cur_d   = inc[apf_pkg::COUNT_W] ? apf_pkg::COUNT_MAX : inc[apf_pkg::COUNT_W-1:0];
      cdesc_d = desc_i;
    end else if (close_en_i) begin
      flag_d = needed;
      if (cur_q == last_q) begin
        cur_d  = '0;
        last_d = '0;
      end else if (cur_q >= thresh_i) begin
        cur_d  = thresh_i;
        last_d = thresh_i;
      end else begin
        last_d = cur_q;
      end
      pdesc_d = cdesc_q;
      cdesc_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= '0;
      last_q  <= '0;
      flag_q  <= 1'b0;
      cdesc_q <= '0;
      pdesc_q <= '0;
    end else begin
      cur_q   <= cur_d;
      last_q  <= last_d;
      flag_q  <= flag_d;
      cdesc_q <= cdesc_d;
      pdesc_q <= pdesc_d;
    end
  end

  assign stat_o.needed       = needed;
  assign stat_o.flag         = flag_q;
  assign stat_o.desc_changed = (cdesc_q != pdesc_q);

endmodule

// ===== design/apf_checker.sv =====
`timescale 1ns / 1ps

`include "alarm_persistence_filter_unit_macros.svh"

module apf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [apf_pkg::KIND_W-1:0]    kind_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [apf_pkg::ACT_W-1:0]     action_o,
  input logic                          alarm_needed_o
);

  // stalled result word holds
  `APF_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o)
  `APF_ASSERT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i |=> $stable(action_o) && $stable(alarm_needed_o))

  // action agrees with the needed flag
  `APF_ASSERT_NEVER(a_add_unneeded, clk_i, rst_ni, out_valid_o && !alarm_needed_o && (action_o == apf_pkg::ACT_ADD || action_o == apf_pkg::ACT_READD))
  `APF_ASSERT_NEVER(a_remove_needed, clk_i, rst_ni, out_valid_o && alarm_needed_o && action_o == apf_pkg::ACT_REMOVE)

  // a fresh result comes from a query that was accepted and then handled without a stall
  `APF_ASSERT(a_result_src, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && kind_i == apf_pkg::KIND_QUERY, 2))

endmodule

bind alarm_persistence_filter_unit apf_checker u_apf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .kind_i         (kind_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .action_o       (action_o),
  .alarm_needed_o (alarm_needed_o)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import apf_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int LATENCY = 2;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [CHAN_W-1:0]    chan;
    logic [DESC_IN_W-1:0] desc;
    logic                 typed;
    logic [ACT_W-1:0]     act;
    logic                 needed;
  } alarm_word_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             needed;
  } alarm_result_t;

  // kind, channel, desc, typed expectation, action, needed
  localparam alarm_word_t DIRECTED [22] = '{
    '{KIND_QUERY,  4'd0,  8'h00, 1'b1, ACT_NONE, 1'b0},
    '{KIND_QUERY,  4'd15, 8'h00, 1'b1, ACT_NONE, 1'b0},
    '{KIND_UNUSED, 4'd5,  8'hAA, 1'b0, ACT_NONE, 1'b0},
    '{KIND_REPORT, 4'd3,  8'hFF, 1'b0, ACT_NONE, 1'b0},
    '{KIND_REPORT, 4'd3,  8'h01, 1'b0, ACT_NONE, 1'b0},
    '{KIND_ROUND,  4'd0,  8'h00, 1'b0, ACT_NONE, 1'b0},
    '{KIND_REPORT, 4'd3,  8'h01, 1'b0, ACT_NONE, 1'b0},
    '{KIND_ROUND,  4'd9,  8'h55, 1'b0, ACT_NONE, 1'b0},
    '{KIND_REPORT, 4'd3,  8'h01, 1'b0, ACT_NONE, 1'b0},
    '{KIND_ROUND,  4'd0,  8'h00, 1'b0, ACT_NONE, 1'b0},
    '{KIND_REPORT, 4'd3,  8'h01, 1'b0, ACT_NONE, 1'b0},
    '{KIND_ROUND,  4'd0,  8'h00, 1'b0, ACT_NONE, 1'b0},
    '{KIND_REPORT, 4'd3,  8'h80, 1'b0, ACT_NONE, 1'b0},
    '{KIND_QUERY,  4'd3,  8'h00, 1'b0, ACT_NONE, 1'b0},
    '{KIND_ROUND,  4'd0,  8'h00, 1'b0, ACT_NONE, 1'b0},
    '{KIND_REPORT, 4'd3,  8'h7F, 1'b0, ACT_NONE, 1'b0},
    '{KIND_QUERY,  4'd3,  8'h00, 1'b0, ACT_NONE, 1'b0},
    '{KIND_ROUND,  4'd0,  8'h00, 1'b0, ACT_NONE, 1'b0},
    '{KIND_QUERY,  4'd3,  8'h00, 1'b0, ACT_NONE, 1'b0},
    '{KIND_REPORT, 4'd0,  8'h00, 1'b0, ACT_NONE, 1'b0},
    '{KIND_QUERY,  4'd0,  8'h00, 1'b0, ACT_NONE, 1'b0},
    '{KIND_ROUND,  4'd0,  8'h00, 1'b0, ACT_NONE, 1'b0}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [COUNT_W-1:0]   cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [KIND_W-1:0]    kind_i = '0;
  logic [CHAN_W-1:0]    channel_i = '0;
  logic [DESC_IN_W-1:0] desc_code_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [ACT_W-1:0]     action_o;
  logic                 alarm_needed_o;

  alarm_persistence_filter_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .channel_i      (channel_i),
    .desc_code_i    (desc_code_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .action_o       (action_o),
    .alarm_needed_o (alarm_needed_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predicted per-channel state
  logic [COUNT_W-1:0]   thr;
  logic [COUNT_W-1:0]   last_cnt [NUM_CHANNELS];
  logic [COUNT_W-1:0]   cur_cnt  [NUM_CHANNELS];
  logic                 raised   [NUM_CHANNELS];
  logic [DESC_BITS-1:0] desc_now [NUM_CHANNELS];
  logic [DESC_BITS-1:0] desc_prev[NUM_CHANNELS];

  alarm_result_t pending_actions[$];
  alarm_result_t want;
  int            err_cnt = 0;
  int            cycle_cnt = 0;
  int            in_idle_pct = 0;
  int            out_idle_pct = 0;
  int            words_sent = 0;
  logic [CHAN_W-1:0]    hot_chan[3];
  logic [DESC_IN_W-1:0] hot_desc[3];

  function automatic logic chan_needed(int c);
    return (cur_cnt[c] > last_cnt[c]) && (cur_cnt[c] >= thr);
  endfunction

  task automatic track_alarm_word(input alarm_word_t w);
    int            c;
    int            n;
    logic          need;
    alarm_result_t r;
    c = int'(w.chan);
    case (w.kind)
      KIND_REPORT: begin
        if (c < NUM_CHANNELS) begin
          n = int'(last_cnt[c]) + 1;
          cur_cnt[c] = (n > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(n);
          desc_now[c] = w.desc[DESC_BITS-1:0];
        end
      end
      KIND_QUERY: begin
        r.act = ACT_NONE;
        r.needed = 1'b0;
        if (c < NUM_CHANNELS) begin
          need = chan_needed(c);
          r.needed = need;
          if (raised[c] == need)
            r.act = (raised[c] && desc_now[c] != desc_prev[c]) ? ACT_READD : ACT_NONE;
          else
            r.act = need ? ACT_ADD : ACT_REMOVE;
        end
        if (w.typed) begin
          r.act = w.act;
          r.needed = w.needed;
        end
        pending_actions.push_back(r);
      end
      KIND_ROUND: begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          raised[i] = chan_needed(i);
          if (cur_cnt[i] == last_cnt[i]) begin
            cur_cnt[i] = '0;
            last_cnt[i] = '0;
          end else if (cur_cnt[i] >= thr) begin
            cur_cnt[i] = thr;
            last_cnt[i] = thr;
          end else begin
            last_cnt[i] = cur_cnt[i];
          end
          desc_prev[i] = desc_now[i];
          desc_now[i] = '0;
        end
      end
      default: ;
    endcase
  endtask

  // called at a rising edge; leaves valid high after the accepting edge
  task automatic send_word(input alarm_word_t w);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= w.kind;
    channel_i   <= w.chan;
    desc_code_i <= w.desc;
    do @(posedge clk_i); while (in_stall_o);
    track_alarm_word(w);
    words_sent++;
  endtask

  task automatic write_threshold(input logic [COUNT_W-1:0] v);
    in_valid_i <= 1'b0;
    while (pending_actions.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    thr = v;
    cfg_we_i <= 1'b0;
  endtask

  function automatic alarm_word_t mk_word(logic [KIND_W-1:0] k, logic [CHAN_W-1:0] ch,
                                          logic [DESC_IN_W-1:0] d);
    alarm_word_t w;
    w = '0;
    w.kind = k;
    w.chan = ch;
    w.desc = d;
    return w;
  endfunction

  // one polling round: hot channels mostly report, queries interleaved
  task automatic run_round();
    alarm_word_t items[$];
    alarm_word_t tmp;
    int          j;
    int          nq;
    for (int h = 0; h < 3; h++) begin
      if ($urandom_range(0, 99) < 85) begin
        if ($urandom_range(0, 99) < 40) hot_desc[h] = DESC_IN_W'($urandom);
        items.push_back(mk_word(KIND_REPORT, hot_chan[h], hot_desc[h]));
      end
    end
    if ($urandom_range(0, 99) < 30)
      items.push_back(mk_word(KIND_REPORT, CHAN_W'($urandom), DESC_IN_W'($urandom)));
    nq = $urandom_range(1, 3);
    for (int q = 0; q < nq; q++) begin
      if ($urandom_range(0, 99) < 70)
        items.push_back(mk_word(KIND_QUERY, hot_chan[$urandom_range(0, 2)],
                                DESC_IN_W'($urandom)));
      else
        items.push_back(mk_word(KIND_QUERY, CHAN_W'($urandom), DESC_IN_W'($urandom)));
    end
    if ($urandom_range(0, 99) < 5)
      items.push_back(mk_word(KIND_UNUSED, CHAN_W'($urandom), DESC_IN_W'($urandom)));
    for (int i = items.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = items[i];
      items[i] = items[j];
      items[j] = tmp;
    end
    foreach (items[i]) send_word(items[i]);
    if ($urandom_range(0, 99) < 95)
      send_word(mk_word(KIND_ROUND, CHAN_W'($urandom), DESC_IN_W'($urandom)));
    if ($urandom_range(0, 99) < 10) hot_chan[$urandom_range(0, 2)] = CHAN_W'($urandom);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_actions.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result word: action %0d needed %0b",
                 $time, action_o, alarm_needed_o);
      end else begin
        want = pending_actions.pop_front();
        if (action_o !== want.act) begin
          err_cnt++;
          $display("%0t: action expected %0d actual %0d", $time, want.act, action_o);
        end
        if (alarm_needed_o !== want.needed) begin
          err_cnt++;
          $display("%0t: alarm_needed expected %0b actual %0b",
                   $time, want.needed, alarm_needed_o);
        end
      end
    end
    out_stall_i <= ($urandom_range(0, 99) < out_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[alarm_persistence_filter_unit] ERROR");
      $finish;
    end
  end

  initial begin
    logic [COUNT_W-1:0] thr_list[9];
    int                 budget;
    thr_list = '{4'd1, 4'd14, 4'd15, 4'd0, 4'd3, 4'd7, 4'd2,
                 COUNT_W'($urandom_range(1, 14)), 4'd5};
    thr = THRESH_RESET;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      last_cnt[c] = '0;
      cur_cnt[c] = '0;
      raised[c] = 1'b0;
      desc_now[c] = '0;
      desc_prev[c] = '0;
    end
    in_idle_pct = 16;
    out_idle_pct = 77;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[i]) send_word(DIRECTED[i]);

    for (int p = 0; p < 9; p++) begin
      write_threshold(thr_list[p]);
      case (p / 3)
        0: begin in_idle_pct = 16; out_idle_pct = 77; end
        1: begin in_idle_pct = 77; out_idle_pct = 16; end
        default: begin in_idle_pct = 0; out_idle_pct = 0; end
      endcase
      for (int h = 0; h < 3; h++) begin
        hot_chan[h] = CHAN_W'($urandom);
        hot_desc[h] = DESC_IN_W'($urandom);
      end
      budget = words_sent + 25 + 8 * int'(thr_list[p]);
      while (words_sent < budget) run_round();
    end

    in_valid_i <= 1'b0;
    while (pending_actions.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
    if (err_cnt == 0)
      $display("[alarm_persistence_filter_unit] OK");
    else
      $display("[alarm_persistence_filter_unit] ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/apf_pkg.sv
design/apf_chan.sv
design/alarm_persistence_filter_unit.sv
design/apf_checker.sv
tb/sv/tb_top.sv
